FILE: hdl/serial_start_word_frame_receiver_macros.svh
// Assertion macros shared by the checker of the frame receiver.
`ifndef SERIAL_START_WORD_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_START_WORD_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSWFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSWFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sswfr_pkg.sv
// Shared constants and types of the start-word frame receiver.
package sswfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int NUM_SLOTS  = 9;
    localparam int RAM_AW     = SLOT_W + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;

    localparam logic [COUNT_W-1:0] POS_IDLE  = 5'd0;
    localparam logic [COUNT_W-1:0] POS_FIRST = 5'd2;
    localparam logic [COUNT_W-1:0] POS_LAST  = 5'd21;
    localparam logic [SLOT_W-1:0]  SLOT_LAST = 4'd8;

    localparam logic [WORD_W-1:0] START_WORD_RESET = 16'hABCD;
    localparam logic [WORD_W-1:0] CHECK_RESET      = 16'd1;

    typedef enum logic [0:0] {
        CFG_START_WORD     = 1'b0,
        CFG_EXPECTED_CHECK = 1'b1
    } cfg_reg_t;

endpackage

FILE: hdl/serial_start_word_frame_receiver.sv
// Top level of the start-word framed serial byte receiver.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_stall      rx_byte
//   output    out_valid / out_stall    frame_ok, frame_id, word0 .. word7
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low. After a frame completes, its
// nine output words are read one per cycle through the single read port of the frame
// RAM. Reset clears all control state at once; no clearing pass.
// The input stalls only while both frame buffers hold completed frames awaiting readout,
// which happens when a waiting result stays stalled long enough for a further frame
// to complete. cfg_ready is always high.
module serial_start_word_frame_receiver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sswfr_pkg::BYTE_W-1:0]       rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               frame_ok,
    output logic signed [sswfr_pkg::WORD_W-1:0] frame_id,
    output logic signed [sswfr_pkg::WORD_W-1:0] word0,
    output logic signed [sswfr_pkg::WORD_W-1:0] word1,
    output logic signed [sswfr_pkg::WORD_W-1:0] word2,
    output logic signed [sswfr_pkg::WORD_W-1:0] word3,
    output logic signed [sswfr_pkg::WORD_W-1:0] word4,
    output logic signed [sswfr_pkg::WORD_W-1:0] word5,
    output logic signed [sswfr_pkg::WORD_W-1:0] word6,
    output logic signed [sswfr_pkg::WORD_W-1:0] word7,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_index,
    input  logic [sswfr_pkg::WORD_W-1:0]       cfg_data
);

    // Configuration registers.
    logic [sswfr_pkg::WORD_W-1:0] start_word_reg;
    logic [sswfr_pkg::WORD_W-1:0] exp_check_reg;

    // Frame assembly state. The frame RAM holds two banks; bytes are paired into
    // little-endian words and written when the high byte arrives. Only the id and
    // the eight data words are stored; the check word is compared on the fly.
    logic [sswfr_pkg::BYTE_W-1:0]  last_byte_reg;
    logic [sswfr_pkg::COUNT_W-1:0] count_reg;
    logic [sswfr_pkg::COUNT_W-1:0] count_next;
    logic [sswfr_pkg::BYTE_W-1:0]  lo_reg;
    logic                          wr_bank_reg;
    logic [1:0]                    pend_reg;
    logic [1:0]                    pend_next;
    logic [1:0]                    pend_ok_reg;

    // Readout sequencer state.
    logic                          rd_bank_reg;
    logic                          rd_busy_reg;
    logic [sswfr_pkg::SLOT_W-1:0]  rd_idx_reg;
    logic                          rd_vld_reg;
    logic [sswfr_pkg::SLOT_W-1:0]  rd_slot_reg;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_ok_reg;
    logic [sswfr_pkg::WORD_W-1:0]  word_reg [sswfr_pkg::NUM_SLOTS];

    logic                          in_fire;
    logic                          out_fire;
    logic                          is_start;
    logic                          collecting;
    logic                          store;
    logic                          done;
    logic [sswfr_pkg::COUNT_W-1:0] pos_off;
    logic [sswfr_pkg::SLOT_W-1:0]  wr_slot;
    logic                          ram_we;
    logic [sswfr_pkg::RAM_AW-1:0]  ram_waddr;
    logic [sswfr_pkg::WORD_W-1:0]  ram_wdata;
    logic [sswfr_pkg::RAM_AW-1:0]  ram_raddr;
    logic [sswfr_pkg::WORD_W-1:0]  ram_rdata;
    logic                          rd_start;
    logic                          rd_land_last;

    assign in_fire  = in_valid & ~in_stall;
    assign out_fire = out_valid_reg & ~out_stall;

    // A new byte would go into the write bank; hold the input while that bank
    // still carries a completed frame that has not been read out.
    assign in_stall = pend_reg[wr_bank_reg];

    assign is_start   = ({rx_byte, last_byte_reg} == start_word_reg);
    assign collecting = count_reg inside {[sswfr_pkg::POS_FIRST:sswfr_pkg::POS_LAST]};
    assign store      = in_fire & ~is_start & collecting;
    assign done       = store & (count_reg == sswfr_pkg::POS_LAST);

    // Frame byte position p (2..21) maps to word slot (p - 2) / 2.
    assign pos_off = count_reg - sswfr_pkg::POS_FIRST;
    assign wr_slot = pos_off[sswfr_pkg::SLOT_W:1];

    // The odd byte of a pair completes a word; the check word is not stored.
    assign ram_we    = store & count_reg[0] & (count_reg != sswfr_pkg::POS_LAST);
    assign ram_waddr = {wr_bank_reg, wr_slot};
    assign ram_wdata = {rx_byte, lo_reg};

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            if (is_start)
            begin
                count_next = sswfr_pkg::POS_FIRST;
            end
            else if (done || !collecting)
            begin
                count_next = sswfr_pkg::POS_IDLE;
            end
            else
            begin
                count_next = count_reg + 5'd1;
            end
        end
    end

    // Readout starts when a completed bank is waiting and the output register is free.
    assign rd_start     = ~rd_busy_reg & ~rd_vld_reg & ~out_valid_reg & pend_reg[rd_bank_reg];
    assign rd_land_last = rd_vld_reg & (rd_slot_reg == sswfr_pkg::SLOT_LAST);
    assign ram_raddr    = {rd_bank_reg, rd_idx_reg};

    // A bank is marked full on completion and released once its last word has landed.
    // The two never address the same bank in one cycle, since completion is only
    // possible into a bank that is not pending.
    always_comb
    begin
        pend_next = pend_reg;
        if (done)
        begin
            pend_next[wr_bank_reg] = 1'b1;
        end
        if (rd_land_last)
        begin
            pend_next[rd_bank_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= sswfr_pkg::START_WORD_RESET;
            exp_check_reg  <= sswfr_pkg::CHECK_RESET;
            last_byte_reg  <= '0;
            count_reg      <= sswfr_pkg::POS_IDLE;
            wr_bank_reg    <= 1'b0;
            pend_reg       <= '0;
            pend_ok_reg    <= '0;
            rd_bank_reg    <= 1'b0;
            rd_busy_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            rd_slot_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (sswfr_pkg::cfg_reg_t'(cfg_index))
                    sswfr_pkg::CFG_START_WORD:     start_word_reg <= cfg_data;
                    sswfr_pkg::CFG_EXPECTED_CHECK: exp_check_reg  <= cfg_data;
                    default:                       ;
                endcase
            end

            if (in_fire)
            begin
                last_byte_reg <= rx_byte;
            end
            count_reg <= count_next;
            pend_reg  <= pend_next;

            // The check word is judged as its high byte arrives.
            if (done)
            begin
                pend_ok_reg[wr_bank_reg] <= ({rx_byte, lo_reg} == exp_check_reg);
                wr_bank_reg              <= ~wr_bank_reg;
            end

            if (rd_start)
            begin
                rd_busy_reg <= 1'b1;
                rd_idx_reg  <= '0;
            end
            else if (rd_busy_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 4'd1;
                if (rd_idx_reg == sswfr_pkg::SLOT_LAST)
                begin
                    rd_busy_reg <= 1'b0;
                end
            end
            rd_vld_reg  <= rd_busy_reg;
            rd_slot_reg <= rd_idx_reg;

            if (rd_land_last)
            begin
                out_valid_reg <= 1'b1;
                rd_bank_reg   <= ~rd_bank_reg;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (store && !count_reg[0])
        begin
            lo_reg <= rx_byte;
        end
        if (rd_vld_reg)
        begin
            word_reg[rd_slot_reg] <= ram_rdata;
        end
        if (rd_land_last)
        begin
            out_ok_reg <= pend_ok_reg[rd_bank_reg];
        end
    end

    sswfr_ram #(
        .WIDTH (sswfr_pkg::WORD_W),
        .DEPTH (sswfr_pkg::RAM_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_busy_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign frame_ok  = out_ok_reg;
    assign frame_id  = word_reg[0];
    assign word0     = word_reg[1];
    assign word1     = word_reg[2];
    assign word2     = word_reg[3];
    assign word3     = word_reg[4];
    assign word4     = word_reg[5];
    assign word5     = word_reg[6];
    assign word6     = word_reg[7];
    assign word7     = word_reg[8];

endmodule

FILE: hdl/sswfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sswfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/sswfr_checker.sv
// Port-level checker for the frame receiver and its bind statement.
`include "serial_start_word_frame_receiver_macros.svh"

module sswfr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          frame_ok,
    input logic [sswfr_pkg::WORD_W-1:0]  frame_id,
    input logic [sswfr_pkg::WORD_W-1:0]  word7,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // A stalled result holds its valid, frame_ok, frame_id and word7.
    `SSWFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(frame_ok) && $stable(frame_id) && $stable(word7), "stalled result changed")

    // A readout starts only once the output register is free, so no result follows directly after a taken one.
    `SSWFR_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, out_valid && !out_stall, !out_valid, "result appeared right after a taken result")

    // Configuration writes are never refused.
    `SSWFR_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind serial_start_word_frame_receiver sswfr_checker u_sswfr_checker (.*);
